// ----- hdl/fpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, types and saturation helpers of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = 32;
   localparam int OP_W      = 4;
   localparam int KIND_W    = 2;
   localparam int DIV_Q_W   = 34;
   localparam int DIV_D_W   = DATA_W + 1;
   localparam int REM_W     = DIV_D_W + DIV_Q_W - 1;
   localparam int PROD_W    = 2 * DATA_W;

   localparam logic [PROD_W-1:0] HALF = (PROD_W'(1) << FRAC_BITS) >> 1;

   localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
   localparam logic [OP_W-1:0] OP_INC  = 4'd4;
   localparam logic [OP_W-1:0] OP_DEC  = 4'd5;
   localparam logic [OP_W-1:0] OP_MIN  = 4'd6;
   localparam logic [OP_W-1:0] OP_MAX  = 4'd7;
   localparam logic [OP_W-1:0] OP_FINT = 4'd8;
   localparam logic [OP_W-1:0] OP_TINT = 4'd9;
   localparam logic [OP_W-1:0] OP_CMP  = 4'd10;

   localparam logic [KIND_W-1:0] KIND_DONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MUL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DIV  = 2'd2;

   localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] NEG_MAX = 32'h8000_0000;

   typedef struct packed {
      logic              ovf;
      logic [DATA_W-1:0] value;
   } sat_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              neg;
      logic [DATA_W-1:0] res;
      logic              ovf;
      logic              dz;
      logic              gt;
      logic              lt;
      logic              eq;
      logic [DATA_W-1:0] mag_a;
      logic [DATA_W-1:0] mag_b;
   } mid_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic               neg;
      logic [DATA_W-1:0]  res;
      logic               ovf;
      logic               dz;
      logic               gt;
      logic               lt;
      logic               eq;
      logic [REM_W-1:0]   rem;
      logic [DIV_D_W-1:0] dvs;
      logic [DIV_Q_W-1:0] quo;
   } stage_type;

   typedef struct packed {
      logic [DATA_W-1:0] res;
      logic              gt;
      logic              lt;
      logic              eq;
      logic              ovf;
      logic              dz;
   } rsp_item_type;

   function automatic sat_type sat_mag(input logic neg, input logic [PROD_W-1:0] mag);
      sat_type r;
      r.ovf = 1'b0;
      if (!neg) begin
         if (mag > PROD_W'(POS_MAX)) begin
            r.ovf   = 1'b1;
            r.value = POS_MAX;
         end else begin
            r.value = mag[DATA_W-1:0];
         end
      end else begin
         if (mag > PROD_W'(NEG_MAX)) begin
            r.ovf   = 1'b1;
            r.value = NEG_MAX;
         end else begin
            r.value = DATA_W'(PROD_W'(0) - mag);
         end
      end
      return r;
   endfunction

   function automatic sat_type sat_sum(input logic [DATA_W:0] s);
      sat_type r;
      r.ovf = s[DATA_W] ^ s[DATA_W-1];
      if (r.ovf) begin
         r.value = s[DATA_W] ? NEG_MAX : POS_MAX;
      end else begin
         r.value = s[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hdl/fixed_point_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed 32-bit fixed-point ALU, FRAC_BITS fraction bits, saturating.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive req_operation, req_operand_a, req_operand_b with
//   req_push; a transaction is taken on a clock edge with req_push high and
//   req_full low.
//   Result channel: while rsp_empty is low the oldest result sits on the rsp_
//   ports; it is taken on an edge with rsp_pop high.
//   Path: from input transaction to rsp_empty falling, every transaction
//   passes the input register, a two-entry decode queue, one multiply stage,
//   34 restoring-divide stages and the result queue.
//   Throughput: one transaction per cycle for every operation, if not stalled.
//   Reset: synchronous; empties all queues and the pipeline, no results
//   remain and req_full drops.
//   Stall: when rsp_pop stays low the result queue fills, the pipeline holds,
//   the decode queue fills and req_full rises; nothing is lost.
// ----------------------------------------------------------------------------
module fixed_point_alu (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [fpa_pkg::OP_W-1:0]          req_operation,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_b,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic signed [fpa_pkg::DATA_W-1:0] rsp_result_value,
   output logic                              rsp_a_greater,
   output logic                              rsp_a_less,
   output logic                              rsp_a_equal,
   output logic                              rsp_overflow,
   output logic                              rsp_divide_by_zero
);

   logic                   mid_valid, mid_pop;
   fpa_pkg::mid_item_type  mid_item;
   fpa_pkg::rsp_item_type  rsp_item;

   fpa_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .mid_valid     (mid_valid),
      .mid_item      (mid_item),
      .mid_pop       (mid_pop)
   );

   fpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_valid (mid_valid),
      .mid_item  (mid_item),
      .mid_pop   (mid_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   assign rsp_result_value   = rsp_item.res;
   assign rsp_a_greater      = rsp_item.gt;
   assign rsp_a_less         = rsp_item.lt;
   assign rsp_a_equal        = rsp_item.eq;
   assign rsp_overflow       = rsp_item.ovf;
   assign rsp_divide_by_zero = rsp_item.dz;

endmodule

// ----- hdl/fpa_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_front
// Input register, operation decode and the short queue toward the back end.
// ----------------------------------------------------------------------------
module fpa_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [fpa_pkg::OP_W-1:0]      req_operation,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_b,
   output logic                          mid_valid,
   output fpa_pkg::mid_item_type         mid_item,
   input  logic                          mid_pop
);

   logic                         f_v_ff, f_v_in;
   logic [fpa_pkg::OP_W-1:0]     f_op_ff;
   logic [fpa_pkg::DATA_W-1:0]   f_a_ff, f_b_ff;
   fpa_pkg::mid_item_type        q_ff [2];
   logic                         wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]                   cnt_ff, cnt_in;
   logic                         accept, mid_full, push, pop;
   fpa_pkg::mid_item_type        cls;
   logic [fpa_pkg::DATA_W-1:0]   mag_a, mag_b, to_int;
   logic [fpa_pkg::DATA_W:0]     sum_ab, dif_ab, inc_a, dec_a;
   fpa_pkg::sat_type             s_add, s_sub, s_inc, s_dec, s_fint;

   assign mid_full = (cnt_ff == 2'd2);
   assign req_full = f_v_ff & mid_full;
   assign accept   = req_push & ~req_full;
   assign push     = f_v_ff & ~mid_full;
   assign pop      = mid_pop & (cnt_ff != 2'd0);
   assign f_v_in   = accept | (f_v_ff & ~push);

   always_comb begin
      mag_a  = f_a_ff[fpa_pkg::DATA_W-1] ? (fpa_pkg::DATA_W'(0) - f_a_ff) : f_a_ff;
      mag_b  = f_b_ff[fpa_pkg::DATA_W-1] ? (fpa_pkg::DATA_W'(0) - f_b_ff) : f_b_ff;
      sum_ab = {f_a_ff[fpa_pkg::DATA_W-1], f_a_ff} + {f_b_ff[fpa_pkg::DATA_W-1], f_b_ff};
      dif_ab = {f_a_ff[fpa_pkg::DATA_W-1], f_a_ff} - {f_b_ff[fpa_pkg::DATA_W-1], f_b_ff};
      inc_a  = {f_a_ff[fpa_pkg::DATA_W-1], f_a_ff} + (fpa_pkg::DATA_W+1)'(1);
      dec_a  = {f_a_ff[fpa_pkg::DATA_W-1], f_a_ff} - (fpa_pkg::DATA_W+1)'(1);
      s_add  = fpa_pkg::sat_sum(sum_ab);
      s_sub  = fpa_pkg::sat_sum(dif_ab);
      s_inc  = fpa_pkg::sat_sum(inc_a);
      s_dec  = fpa_pkg::sat_sum(dec_a);
      s_fint = fpa_pkg::sat_mag(f_a_ff[fpa_pkg::DATA_W-1],
                                fpa_pkg::PROD_W'(mag_a) << fpa_pkg::FRAC_BITS);
      to_int = fpa_pkg::DATA_W'($signed(f_a_ff) >>> fpa_pkg::FRAC_BITS);

      cls       = '0;
      cls.kind  = fpa_pkg::KIND_DONE;
      cls.mag_a = mag_a;
      cls.mag_b = mag_b;
      cls.neg   = f_a_ff[fpa_pkg::DATA_W-1] ^ f_b_ff[fpa_pkg::DATA_W-1];
      cls.gt    = $signed(f_a_ff) > $signed(f_b_ff);
      cls.lt    = $signed(f_a_ff) < $signed(f_b_ff);
      cls.eq    = (f_a_ff == f_b_ff);
      case (f_op_ff)
         fpa_pkg::OP_ADD: begin
            cls.res = s_add.value;
            cls.ovf = s_add.ovf;
         end
         fpa_pkg::OP_SUB: begin
            cls.res = s_sub.value;
            cls.ovf = s_sub.ovf;
         end
         fpa_pkg::OP_MUL: begin
            cls.kind = fpa_pkg::KIND_MUL;
         end
         fpa_pkg::OP_DIV: begin
            if (f_b_ff == '0) begin
               cls.dz = 1'b1;
            end else begin
               cls.kind = fpa_pkg::KIND_DIV;
            end
         end
         fpa_pkg::OP_INC: begin
            cls.res = s_inc.value;
            cls.ovf = s_inc.ovf;
         end
         fpa_pkg::OP_DEC: begin
            cls.res = s_dec.value;
            cls.ovf = s_dec.ovf;
         end
         fpa_pkg::OP_MIN: begin
            cls.res = cls.lt ? f_a_ff : f_b_ff;
         end
         fpa_pkg::OP_MAX: begin
            cls.res = cls.gt ? f_a_ff : f_b_ff;
         end
         fpa_pkg::OP_FINT: begin
            cls.res = s_fint.value;
            cls.ovf = s_fint.ovf;
         end
         fpa_pkg::OP_TINT: begin
            cls.res = to_int;
         end
         default: begin
            cls.res = '0;
         end
      endcase
   end

   assign wr_in  = push ? ~wr_ff : wr_ff;
   assign rd_in  = pop ? ~rd_ff : rd_ff;
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);

   assign mid_valid = (cnt_ff != 2'd0);
   assign mid_item  = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         f_v_ff <= f_v_in;
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_op_ff <= req_operation;
         f_a_ff  <= req_operand_a;
         f_b_ff  <= req_operand_b;
      end
      if (push) begin
         q_ff[wr_ff] <= cls;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("mid queue count out of range");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (f_v_ff && mid_full && !pop) |=> (f_v_ff && cnt_ff == 2'd2))
      else $error("stalled front transaction lost");
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (req_push && req_full) |=> f_v_ff)
      else $error("front transaction dropped while full");
`endif

endmodule

// ----- hdl/fpa_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_back
// Stallable execution pipeline: multiplier, restoring divider stages,
// rounding and saturation, and the result queue.
// ----------------------------------------------------------------------------
module fpa_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          mid_valid,
   input  fpa_pkg::mid_item_type         mid_item,
   output logic                          mid_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output fpa_pkg::rsp_item_type         rsp_item
);

   localparam int LAST = fpa_pkg::DIV_Q_W;

   fpa_pkg::stage_type           s_ff [0:LAST];
   logic [LAST:0]                v_ff;
   fpa_pkg::stage_type           s0_in;
   logic [fpa_pkg::PROD_W-1:0]   prod;
   logic                         en;
   fpa_pkg::rsp_item_type        fin;
   fpa_pkg::sat_type             s_mul, s_div;
   logic [fpa_pkg::PROD_W-1:0]   mul_mag;
   fpa_pkg::rsp_item_type        q_ff [2];
   logic                         wr_ff, rd_ff, push, pop;
   logic [1:0]                   cnt_ff;

   assign en      = ~v_ff[LAST] | (cnt_ff != 2'd2);
   assign mid_pop = en & mid_valid;
   assign prod    = mid_item.mag_a * mid_item.mag_b;

   always_comb begin
      s0_in      = '0;
      s0_in.kind = mid_item.kind;
      s0_in.neg  = mid_item.neg;
      s0_in.res  = mid_item.res;
      s0_in.ovf  = mid_item.ovf;
      s0_in.dz   = mid_item.dz;
      s0_in.gt   = mid_item.gt;
      s0_in.lt   = mid_item.lt;
      s0_in.eq   = mid_item.eq;
      s0_in.dvs  = {mid_item.mag_b, 1'b0};
      if (mid_item.kind == fpa_pkg::KIND_MUL) begin
         s0_in.rem = fpa_pkg::REM_W'(prod);
      end else begin
         s0_in.rem = (fpa_pkg::REM_W'(mid_item.mag_a) << (fpa_pkg::FRAC_BITS + 1))
                     + fpa_pkg::REM_W'(mid_item.mag_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= mid_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff[0] <= s0_in;
      end
   end

   for (genvar k = 0; k < LAST; k++) begin : g_div
      localparam int SH = LAST - 1 - k;
      fpa_pkg::stage_type        nxt;
      logic [fpa_pkg::REM_W-1:0] trial;

      always_comb begin
         nxt   = s_ff[k];
         trial = fpa_pkg::REM_W'(s_ff[k].dvs) << SH;
         if (s_ff[k].kind == fpa_pkg::KIND_DIV && s_ff[k].rem >= trial) begin
            nxt.rem     = s_ff[k].rem - trial;
            nxt.quo[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[k+1] <= nxt;
         end
      end
   end

   always_comb begin
      mul_mag = (s_ff[LAST].rem[fpa_pkg::PROD_W-1:0] + fpa_pkg::HALF) >> fpa_pkg::FRAC_BITS;
      s_mul   = fpa_pkg::sat_mag(s_ff[LAST].neg, mul_mag);
      s_div   = fpa_pkg::sat_mag(s_ff[LAST].neg, fpa_pkg::PROD_W'(s_ff[LAST].quo));
      fin.gt  = s_ff[LAST].gt;
      fin.lt  = s_ff[LAST].lt;
      fin.eq  = s_ff[LAST].eq;
      fin.dz  = s_ff[LAST].dz;
      case (s_ff[LAST].kind)
         fpa_pkg::KIND_MUL: begin
            fin.res = s_mul.value;
            fin.ovf = s_mul.ovf;
         end
         fpa_pkg::KIND_DIV: begin
            fin.res = s_div.value;
            fin.ovf = s_div.ovf;
         end
         default: begin
            fin.res = s_ff[LAST].res;
            fin.ovf = s_ff[LAST].ovf;
         end
      endcase
   end

   assign push      = v_ff[LAST] & en;
   assign pop       = rsp_pop & (cnt_ff != 2'd0);
   assign rsp_empty = (cnt_ff == 2'd0);
   assign rsp_item  = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= push ? ~wr_ff : wr_ff;
         rd_ff  <= pop ? ~rd_ff : rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= fin;
      end
   end

`ifndef SYNTHESIS
   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("result queue count out of range");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (v_ff[LAST] && !en) |=> v_ff[LAST]) else $error("stalled result dropped");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> (cnt_ff == 2'd2))
      else $error("result queue overrun");
`endif

endmodule

// ----- test/fixed_point_alu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_checker
// Watches both channels of the fixed-point ALU, predicts each result from the
// accepted input transaction and compares it field by field in order.
// ----------------------------------------------------------------------------
module fixed_point_alu_checker
   import fpa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  logic                     req_full,
   input  logic [OP_W-1:0]          req_operation,
   input  logic signed [DATA_W-1:0] req_operand_a,
   input  logic signed [DATA_W-1:0] req_operand_b,
   input  logic                     rsp_empty,
   input  logic                     rsp_pop,
   input  logic signed [DATA_W-1:0] rsp_result_value,
   input  logic                     rsp_a_greater,
   input  logic                     rsp_a_less,
   input  logic                     rsp_a_equal,
   input  logic                     rsp_overflow,
   input  logic                     rsp_divide_by_zero,
   output int                       fail_count,
   output int                       pending_count
);

   typedef struct {
      logic [DATA_W-1:0] value;
      logic              gt;
      logic              lt;
      logic              eq;
      logic              ovf;
      logic              dz;
   } alu_result_type;

   alu_result_type expected_results[$];

   function automatic logic [DATA_W-1:0] clamp(input logic neg,
                                               input logic [63:0] mag,
                                               inout logic ovf);
      if (!neg) begin
         if (mag > 64'h7FFF_FFFF) begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
         end
         return mag[31:0];
      end
      if (mag > 64'h8000_0000) begin
         ovf = 1'b1;
         return 32'h8000_0000;
      end
      return 32'(64'd0 - mag);
   endfunction

   function automatic logic [63:0] abs64(input longint s);
      return (s < 0) ? 64'(-s) : 64'(s);
   endfunction

   function automatic alu_result_type compute_alu(input logic [OP_W-1:0] op,
                                                  input logic signed [31:0] a_in,
                                                  input logic signed [31:0] b_in);
      alu_result_type r;
      longint a, b, p;
      logic [63:0] ma, mb, q;
      logic ovf;
      a = a_in;
      b = b_in;
      ovf = 1'b0;
      r.value = '0;
      r.dz = 1'b0;
      case (op)
         OP_ADD: r.value = clamp(a + b < 0, abs64(a + b), ovf);
         OP_SUB: r.value = clamp(a - b < 0, abs64(a - b), ovf);
         OP_MUL: begin
            p = a * b;
            r.value = clamp(p < 0, (abs64(p) + HALF) >> FRAC_BITS, ovf);
         end
         OP_DIV: begin
            if (b == 0) begin
               r.dz = 1'b1;
            end else begin
               ma = abs64(a);
               mb = abs64(b);
               q = (((ma << FRAC_BITS) << 1) + mb) / (mb << 1);
               r.value = clamp((a < 0) != (b < 0), q, ovf);
            end
         end
         OP_INC: r.value = clamp(a + 1 < 0, abs64(a + 1), ovf);
         OP_DEC: r.value = clamp(a - 1 < 0, abs64(a - 1), ovf);
         OP_MIN: r.value = (a < b) ? a_in : b_in;
         OP_MAX: r.value = (a > b) ? a_in : b_in;
         OP_FINT: r.value = clamp(a < 0, abs64(a) << FRAC_BITS, ovf);
         OP_TINT: r.value = a_in >>> FRAC_BITS;
         default: r.value = '0;
      endcase
      r.ovf = ovf;
      r.gt = a > b;
      r.lt = a < b;
      r.eq = a == b;
      return r;
   endfunction

   always @(posedge clock) begin
      alu_result_type e;
      if (reset) begin
         expected_results.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_push && !req_full)
            expected_results.push_back(compute_alu(req_operation, req_operand_a,
                                                   req_operand_b));
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected result transaction %h", rsp_result_value);
            end else begin
               e = expected_results.pop_front();
               if (e.value !== rsp_result_value || e.gt !== rsp_a_greater ||
                   e.lt !== rsp_a_less || e.eq !== rsp_a_equal ||
                   e.ovf !== rsp_overflow || e.dz !== rsp_divide_by_zero) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch exp %h %b%b%b%b%b got %h %b%b%b%b%b",
                              e.value, e.gt, e.lt, e.eq, e.ovf, e.dz,
                              rsp_result_value, rsp_a_greater, rsp_a_less,
                              rsp_a_equal, rsp_overflow, rsp_divide_by_zero);
               end
            end
         end
         pending_count <= expected_results.size();
      end
   end

endmodule

// ----- test/tb_fixed_point_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu
// Drives directed corner operations and random operations with random gaps
// and result stalls into the fixed-point ALU; the checker judges results.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu;
   import fpa_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int IDLE_LIMIT   = 20000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   logic                     req_full;
   logic [OP_W-1:0]          req_operation = '0;
   logic signed [DATA_W-1:0] req_operand_a = '0;
   logic signed [DATA_W-1:0] req_operand_b = '0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic                     rsp_a_greater, rsp_a_less, rsp_a_equal;
   logic                     rsp_overflow, rsp_divide_by_zero;
   int                       fail_count, pending_count;
   int                       idle_cycles = 0;
   bit                       stimulus_done = 1'b0;
   bit                       hold_off = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   fixed_point_alu i_dut (.*);
   fixed_point_alu_checker i_checker (.*);

   function automatic int gap_length();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'(int'($urandom_range(0, 16)) - 8);
         3: return 32'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
         4: return 32'($urandom_range(0, 3) << 8);
         default: return $urandom;
      endcase
   endfunction

   task automatic send(input logic [OP_W-1:0] op, input logic [31:0] a,
                       input logic [31:0] b);
      req_push      <= 1'b1;
      req_operation <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic pause_sender(input int n);
      if (n > 0) begin
         req_push <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : receiver
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_pop <= 1'b0;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         gap = stimulus_done ? 0 : gap_length();
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin : sender
      logic [OP_W-1:0] op;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(OP_ADD, 32'h7FFF_FFFF, 32'h1);
      send(OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
      send(OP_SUB, 32'h8000_0000, 32'h1);
      send(OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000);
      send(OP_MUL, 32'h0000_0180, 32'hFFFF_FF80);
      send(OP_MUL, 32'h8000_0000, 32'h8000_0000);
      send(OP_MUL, 32'h0000_0001, 32'h0000_0080);
      send(OP_DIV, 32'h0000_0100, 32'h0);
      send(OP_DIV, 32'h7FFF_FFFF, 32'h1);
      send(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      send(OP_DIV, 32'hFFFF_FF00, 32'h0000_0300);
      send(OP_INC, 32'h7FFF_FFFF, 32'h0);
      send(OP_DEC, 32'h8000_0000, 32'h0);
      send(OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
      send(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
      send(OP_FINT, 32'h0080_0000, 32'h0);
      send(OP_FINT, 32'hFF80_0000, 32'h0);
      send(OP_FINT, 32'hFF7F_FFFF, 32'h5);
      send(OP_TINT, 32'hFFFF_FF01, 32'h0);
      send(OP_TINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send(OP_CMP, 32'h5, 32'h5);
      send(4'd11, 32'h3, 32'h2);
      send(4'd15, 32'hFFFF_FFFF, 32'h0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) hold_off = 1'b1;
         if (!hold_off) pause_sender(gap_length());
         op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(11, 15))
                                           : 4'($urandom_range(0, 10));
         send(op, pick_operand(), pick_operand());
      end
      req_push <= 1'b0;
      stimulus_done = 1'b1;
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
